>>> hw/rtl/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared widths, command and status codes for the region registry table.
// ----------------------------------------------------------------------------
package rrt_pkg;

	localparam int MAX_ENTRIES_DEF = 16;

	localparam int ADDR_W   = 48;
	localparam int SIZE_W   = 40;
	localparam int TOTAL_W  = 44;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int ENTRY_W  = ADDR_W + SIZE_W;

	localparam logic CMD_REGISTER   = 1'b0;
	localparam logic CMD_UNREGISTER = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

	typedef logic [ENTRY_W-1:0] entry_t;

endpackage

>>> hw/rtl/rrt_ram.sv
// ----------------------------------------------------------------------------
// rrt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/region_registry_table.sv
// ----------------------------------------------------------------------------
// region_registry_table
// Bounded table of memory regions (address, byte size) with an entry count
// and a running byte total. Register appends, unregister swaps the last entry
// into the freed slot. One response item per command item.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   cmd      | cmd_valid, cmd_stall | command, region_address, region_size
//   rsp      | rsp_valid, rsp_stall | status, entry_count, total_bytes
//
// A non-null command scans the held entries, one table read per cycle
// through the single RAM read port, then an append or a last-entry move;
// a null command goes straight to the response. cmd_stall is high from
// acceptance until the response is loaded into the output register; the
// output register holds it while rsp_stall is high. Reset clears count
// and total; table entries stay undefined until written.
// ----------------------------------------------------------------------------
module region_registry_table
	import rrt_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  logic                command,
	input  logic [ADDR_W-1:0]   region_address,
	input  logic [SIZE_W-1:0]   region_size,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_W-1:0]  entry_count,
	output logic [TOTAL_W-1:0]  total_bytes
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_APPEND = 3'd2;
	localparam logic [2:0] S_LAST   = 3'd3;
	localparam logic [2:0] S_MOVE   = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                cmd_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [SIZE_W-1:0]   size_q;
	logic [STATUS_W-1:0] st_q;
	logic [CNT_W-1:0]    issue_q;
	logic [CNT_W-1:0]    slot_q;
	logic                scan_vld_s1;
	logic [CNT_W-1:0]    rd_idx_s1;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  entry_count_q;
	logic [TOTAL_W-1:0]  total_bytes_q;

	logic                ram_wr_en;
	logic [IDX_W-1:0]    ram_wr_addr;
	entry_t              ram_wr_data;
	logic                ram_rd_en;
	logic [IDX_W-1:0]    ram_rd_addr;
	entry_t              ram_rd_data;

	logic [ADDR_W-1:0]   rd_addr_fld;
	logic [SIZE_W-1:0]   rd_size_fld;
	logic                hit;
	logic                at_last;
	logic                full;
	logic [CNT_W-1:0]    last_idx;
	logic                alu_sub;
	logic [TOTAL_W-1:0]  alu_opnd;
	logic [TOTAL_W-1:0]  alu_res;
	logic                accept;
	logic                rsp_free;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	assign accept      = cmd_valid && !cmd_stall;
	assign cmd_stall   = (state_q != S_IDLE);
	assign rsp_free    = !rsp_valid_q || !rsp_stall;
	assign rd_addr_fld = ram_rd_data[ENTRY_W-1:SIZE_W];
	assign rd_size_fld = ram_rd_data[SIZE_W-1:0];
	assign hit         = scan_vld_s1 && (rd_addr_fld == addr_q);
	assign last_idx    = cnt_q - CNT_W'(1);
	assign at_last     = (rd_idx_s1 == last_idx);
	assign full        = (cnt_q == CNT_W'(MAX_ENTRIES));
	assign cnt_ext     = {{COUNT_W{1'b0}}, cnt_q};

	// shared add/subtract unit for the running total
	always_comb begin
		alu_sub  = (state_q == S_SCAN);
		alu_opnd = alu_sub ? {{(TOTAL_W-SIZE_W){1'b0}}, rd_size_fld}
		                   : {{(TOTAL_W-SIZE_W){1'b0}}, size_q};
		alu_res  = alu_sub ? (total_q - alu_opnd) : (total_q + alu_opnd);
	end

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = issue_q[IDX_W-1:0];
		ram_wr_en   = 1'b0;
		ram_wr_addr = cnt_q[IDX_W-1:0];
		ram_wr_data = {addr_q, size_q};
		case (state_q)
			S_SCAN: begin
				ram_rd_en = (issue_q < cnt_q);
			end
			S_LAST: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = last_idx[IDX_W-1:0];
			end
			S_APPEND: begin
				ram_wr_en = (cmd_q == CMD_REGISTER) && !full;
			end
			S_MOVE: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = slot_q[IDX_W-1:0];
				ram_wr_data = ram_rd_data;
			end
			default: begin
			end
		endcase
	end

	rrt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			total_q     <= '0;
			scan_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			scan_vld_s1 <= (state_q == S_SCAN) && ram_rd_en;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (region_address == '0 ||
						    (command == CMD_REGISTER && region_size == '0)) begin
							state_q <= S_DONE;
						end else if (cnt_q == '0) begin
							state_q <= S_APPEND;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (cmd_q == CMD_REGISTER) begin
							state_q <= S_DONE;
						end else begin
							total_q <= alu_res;
							state_q <= S_LAST;
						end
					end else if (scan_vld_s1 && at_last) begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					if (cmd_q == CMD_REGISTER && !full) begin
						total_q <= alu_res;
						cnt_q   <= cnt_q + CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_LAST: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					cnt_q   <= last_idx;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload, status, scan bookkeeping and response output registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q   <= command;
					addr_q  <= region_address;
					size_q  <= region_size;
					issue_q <= '0;
					st_q    <= ST_NULL;
				end
			end
			S_SCAN: begin
				if (ram_rd_en) begin
					issue_q <= issue_q + CNT_W'(1);
				end
				rd_idx_s1 <= issue_q;
				if (hit) begin
					slot_q <= rd_idx_s1;
					st_q   <= (cmd_q == CMD_REGISTER) ? ST_PRESENT : ST_REMOVED;
				end
			end
			S_APPEND: begin
				if (cmd_q == CMD_UNREGISTER) begin
					st_q <= ST_NOT_FOUND;
				end else if (full) begin
					st_q <= ST_FULL;
				end else begin
					st_q <= ST_ADDED;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					status_q      <= st_q;
					entry_count_q <= cnt_ext[COUNT_W-1:0];
					total_bytes_q <= total_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign total_bytes = total_bytes_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above table depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && scan_vld_s1) |-> (rd_idx_s1 < cnt_q))
		else $error("scan compared an entry beyond the held count");

	a_move_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |-> (cnt_q != '0 && slot_q < cnt_q))
		else $error("entry move with empty table or bad slot");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_DONE && state_q == S_IDLE))
		else $error("response raised outside the done step");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
			($past(state_q) == S_APPEND || $past(state_q) == S_MOVE))
		else $error("entry count changed outside append or move");

endmodule
